### rtl/mnsq_pkg.sv
// ----------------------------------------------------------------------------
// mnsq_pkg
// Shared types, constants and lookup functions for the MIDI note scale
// quantizer: scale patterns, register indexes and pitch-class helpers.
// ----------------------------------------------------------------------------
package mnsq_pkg;

  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned PC_N     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SELECT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NOTE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_AMOUNT = 2'd2;

  // status high nibbles that are kept
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  typedef logic [PC_N-1:0] pc_mask_t;

  // settings handed from the register block to the datapath
  typedef struct packed {
    pc_mask_t          member_mask;  // bit k set: pitch class k is in the scale
    logic [NOTE_W-1:0] transpose;
  } mnsq_cfg_t;

  // scale pattern relative to the root; bit j is scale degree j
  function automatic pc_mask_t scale_pattern(input logic [3:0] sel);
    pc_mask_t pat;
    case (sel)
      4'd0:    pat = 12'b1111_1111_1111;
      4'd1:    pat = 12'b1010_1011_0101;  // ionian
      4'd2:    pat = 12'b0110_1010_1101;  // dorian
      4'd3:    pat = 12'b0101_1010_1011;  // phrygian
      4'd4:    pat = 12'b1010_1101_0101;  // lydian
      4'd5:    pat = 12'b0110_1011_0101;  // mixolydian
      4'd6:    pat = 12'b0101_1010_1101;  // aeolian
      4'd7:    pat = 12'b0101_0110_1011;  // locrian
      4'd8:    pat = 12'b0000_1001_0001;  // triad I
      4'd9:    pat = 12'b0010_0010_0100;  // triad II
      4'd10:   pat = 12'b1000_1001_0000;  // triad III
      4'd11:   pat = 12'b0010_0010_0001;  // triad IV
      4'd12:   pat = 12'b1000_1000_0100;  // triad V
      4'd13:   pat = 12'b0010_0001_0001;  // triad VI
      4'd14:   pat = 12'b1000_0010_0100;  // triad VII
      default: pat = 12'b1111_1111_1111;  // unused code acts as chromatic
    endcase
    return pat;
  endfunction

  // pitch class of a note: n - 12 * floor(n * 43 / 512), exact over 0..127
  function automatic logic [3:0] note_pc(input logic [NOTE_W-1:0] note);
    logic [12:0] prod;
    logic [3:0]  oct;
    logic [NOTE_W-1:0] base;
    prod = {6'd0, note} * 13'd43;
    oct  = prod[12:9];
    base = NOTE_W'({3'd0, oct} * 7'd12);
    return 4'(note - base);
  endfunction

endpackage

### rtl/mnsq_ifs.sv
// ----------------------------------------------------------------------------
// mnsq_ifs
// Valid/ready channels of the quantizer: incoming MIDI message and
// quantized result.
// ----------------------------------------------------------------------------
interface mnsq_msg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] note_number;
  logic [6:0] velocity;

  modport source (output valid, output status_byte, output note_number,
                  output velocity, input ready);
  modport sink   (input valid, input status_byte, input note_number,
                  input velocity, output ready);
endinterface

interface mnsq_msg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_status;
  logic [6:0] out_note;
  logic [6:0] out_velocity;

  modport source (output valid, output out_status, output out_note,
                  output out_velocity, input ready);
  modport sink   (input valid, input out_status, input out_note,
                  input out_velocity, output ready);
endinterface

### rtl/mnsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// mnsq_cfg_regs
// Configuration registers; turns scale select and root into a pitch-class
// membership mask for the datapath.
// ----------------------------------------------------------------------------
module mnsq_cfg_regs
  import mnsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output mnsq_cfg_t             cfg_o
);

  logic [3:0]        scale_sel_r;
  logic [3:0]        root_r;
  logic [NOTE_W-1:0] transpose_r;

  // register writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_sel_r <= '0;
      root_r      <= '0;
      transpose_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_SELECT:     scale_sel_r <= cfg_data[3:0];
        CFG_ROOT_NOTE:        root_r      <= cfg_data[3:0];
        CFG_TRANSPOSE_AMOUNT: transpose_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // rotate the pattern up by the root, root taken modulo 12
  logic [3:0] root_mod;
  pc_mask_t   pat;
  pc_mask_t   mask;

  always_comb begin
    root_mod = (root_r >= 4'd12) ? root_r - 4'd12 : root_r;
    pat      = scale_pattern(scale_sel_r);
    for (int k = 0; k < PC_N; k++) begin
      logic [4:0] idx;
      idx = 5'(k) + 5'd12 - {1'b0, root_mod};
      if (idx >= 5'd12) idx = idx - 5'd12;
      mask[k] = pat[idx[3:0]];
    end
  end

  assign cfg_o.member_mask = mask;
  assign cfg_o.transpose   = transpose_r;

endmodule

### rtl/midi_note_scale_quantizer.sv
// ----------------------------------------------------------------------------
// midi_note_scale_quantizer
// Keeps note-on/note-off messages, snaps the note to the nearest scale note
// (upper wins a tie), adds the transpose and saturates at 127.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   status_byte[8] note_number[7] velocity[7]
//   out_ch   out  valid/ready   out_status[8] out_note[7] out_velocity[7]
//   cfg_*    in   write enable  cfg_index[2] cfg_data[7]
//
// One message per cycle while the output is not stalled; a kept message passes
// through the four register stages (pitch class, candidate search, nearest
// pick, transpose and output register) before it is presented at the output.
// Other messages are taken and dropped at the first stage.
// Synchronous active-low reset clears all stage valid bits; data registers are not reset.
// A stalled output holds each full stage with no empty stage after it; empty stages keep filling.
// ----------------------------------------------------------------------------
module midi_note_scale_quantizer
  import mnsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mnsq_msg_in_if.sink           in_ch,
  mnsq_msg_out_if.source        out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mnsq_cfg_t cfg;

  mnsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // stage advance enables, back from the output
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !s4_valid_r || out_ch.ready;
  assign adv3 = !s3_valid_r || adv4;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;

  logic in_xfer;
  logic in_kept;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_kept = (in_ch.status_byte[7:4] == KIND_NOTE_OFF) ||
                   (in_ch.status_byte[7:4] == KIND_NOTE_ON);

  // stage 1: capture message and its pitch class
  logic [STATUS_W-1:0] s1_status_r;
  logic [NOTE_W-1:0]   s1_note_r, s1_vel_r;
  logic [3:0]          s1_pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (adv1) s1_valid_r <= in_xfer && in_kept;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_status_r <= in_ch.status_byte;
      s1_note_r   <= in_ch.note_number;
      s1_vel_r    <= in_ch.velocity;
      s1_pc_r     <= note_pc(in_ch.note_number);
    end
  end

  // stage 2: scale membership of the notes up to 11 steps above and below
  pc_mask_t up_ok_nxt, dn_ok_nxt;
  pc_mask_t up_ok_r, dn_ok_r;
  logic [STATUS_W-1:0] s2_status_r;
  logic [NOTE_W-1:0]   s2_note_r, s2_vel_r;

  always_comb begin
    for (int d = 0; d < PC_N; d++) begin
      logic [4:0] up_pc, dn_pc;
      up_pc = {1'b0, s1_pc_r} + 5'(d);
      if (up_pc >= 5'd12) up_pc = up_pc - 5'd12;
      dn_pc = {1'b0, s1_pc_r} + 5'd12 - 5'(d);
      if (dn_pc >= 5'd12) dn_pc = dn_pc - 5'd12;
      up_ok_nxt[d] = ({1'b0, s1_note_r} + 8'(d) <= {1'b0, NOTE_MAX}) &&
                     cfg.member_mask[up_pc[3:0]];
      dn_ok_nxt[d] = (s1_note_r >= NOTE_W'(d)) && cfg.member_mask[dn_pc[3:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (adv2) s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      up_ok_r     <= up_ok_nxt;
      dn_ok_r     <= dn_ok_nxt;
      s2_status_r <= s1_status_r;
      s2_note_r   <= s1_note_r;
      s2_vel_r    <= s1_vel_r;
    end
  end

  // stage 3: nearest candidate, upper first at equal distance
  logic [3:0]        pick_d;
  logic              pick_up;
  logic [NOTE_W-1:0] snap_nxt;
  logic [NOTE_W-1:0] s3_snap_r, s3_vel_r;
  logic [STATUS_W-1:0] s3_status_r;

  always_comb begin
    pick_d  = '0;
    pick_up = 1'b1;
    for (int d = PC_N - 1; d >= 0; d--) begin
      if (dn_ok_r[d]) begin
        pick_d  = 4'(d);
        pick_up = 1'b0;
      end
      if (up_ok_r[d]) begin
        pick_d  = 4'(d);
        pick_up = 1'b1;
      end
    end
    snap_nxt = pick_up ? s2_note_r + NOTE_W'(pick_d) : s2_note_r - NOTE_W'(pick_d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (adv3) s3_valid_r <= s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_snap_r   <= snap_nxt;
      s3_status_r <= s2_status_r;
      s3_vel_r    <= s2_vel_r;
    end
  end

  // stage 4: transpose with saturation into the output register
  logic [NOTE_W:0]     sum;
  logic [NOTE_W-1:0]   note_nxt;
  logic [NOTE_W-1:0]   s4_note_r, s4_vel_r;
  logic [STATUS_W-1:0] s4_status_r;

  assign sum      = {1'b0, s3_snap_r} + {1'b0, cfg.transpose};
  assign note_nxt = (sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : sum[NOTE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else if (adv4) s4_valid_r <= s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_note_r   <= note_nxt;
      s4_status_r <= s3_status_r;
      s4_vel_r    <= s3_vel_r;
    end
  end

  assign out_ch.valid        = s4_valid_r;
  assign out_ch.out_status   = s4_status_r;
  assign out_ch.out_note     = s4_note_r;
  assign out_ch.out_velocity = s4_vel_r;

  // a transfer of a message that is not a note message never enters the pipe
  a_drop_other: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_kept) |=> !s1_valid_r)
    else $error("non-note message entered the pipeline");

  // every searched message has at least one scale note in reach
  a_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> ((up_ok_r != '0) || (dn_ok_r != '0)))
    else $error("no scale candidate found");

  // only note messages leave the block
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_status[7:5] == 3'b100))
    else $error("result with a non-note status");

  // a full stage 3 behind a stalled output is held
  a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && !out_ch.ready && s3_valid_r) |=> (s3_valid_r && $stable(s3_snap_r)))
    else $error("stage 3 lost during a stall");

endmodule

### tb/tb_midi_note_scale_quantizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_note_scale_quantizer
// Self-checking bench for the MIDI note scale quantizer. A directed part covers
// the status, note and velocity extremes, ties, saturation and the odd register
// codes. Random configuration phases follow, each carrying note-on/note-off
// traffic with some other messages mixed in, under varying source and sink
// stalls. A scoreboard predicts every kept message and checks results in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] status;
  logic [6:0] note;
  logic [6:0] velocity;
} midi_msg_t;

class note_quant_board;
  logic [3:0] scale_sel;
  logic [3:0] root;
  logic [6:0] transpose;
  midi_msg_t  pending_notes[$];
  int         errors;

  function new();
    scale_sel = '0;
    root      = '0;
    transpose = '0;
    errors    = 0;
  endfunction

  // shadow copy of the registers, as the block applies them
  function void write_reg(logic [mnsq_pkg::CFG_IDX_W-1:0] idx,
                          logic [mnsq_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mnsq_pkg::CFG_SCALE_SELECT:     scale_sel = data[3:0];
      mnsq_pkg::CFG_ROOT_NOTE:        root      = data[3:0];
      mnsq_pkg::CFG_TRANSPOSE_AMOUNT: transpose = data[6:0];
      default: ;
    endcase
  endfunction

  // scale degrees from the root, degree 0 leftmost
  function bit [0:11] degree_pattern(logic [3:0] sel);
    case (sel)
      4'd1:    return 12'b1010_1101_0101;  // ionian
      4'd2:    return 12'b1011_0101_0110;  // dorian
      4'd3:    return 12'b1101_0101_1010;  // phrygian
      4'd4:    return 12'b1010_1011_0101;  // lydian
      4'd5:    return 12'b1010_1101_0110;  // mixolydian
      4'd6:    return 12'b1011_0101_1010;  // aeolian
      4'd7:    return 12'b1101_0110_1010;  // locrian
      4'd8:    return 12'b1000_1001_0000;  // triad I
      4'd9:    return 12'b0010_0100_0100;  // triad II
      4'd10:   return 12'b0000_1001_0001;  // triad III
      4'd11:   return 12'b1000_0100_0100;  // triad IV
      4'd12:   return 12'b0010_0001_0001;  // triad V
      4'd13:   return 12'b1000_1000_0100;  // triad VI
      4'd14:   return 12'b0010_0100_0001;  // triad VII
      default: return 12'b1111_1111_1111;  // chromatic, also the unused code
    endcase
  endfunction

  // nearest scale note over 0..127, upper note first on a tie
  function int snap_to_scale(int note);
    bit [0:11] pat;
    int        r;
    int        d;
    pat = degree_pattern(scale_sel);
    r   = int'(root) % 12;
    for (d = 0; d <= 127; d++) begin
      if (note + d <= 127 && pat[(note + d + 24 - r) % 12]) return note + d;
      if (note - d >= 0 && pat[(note - d + 24 - r) % 12]) return note - d;
    end
    return note;
  endfunction

  // queue the expected result of an accepted message, if it is kept
  function void note_input(midi_msg_t msg);
    midi_msg_t want;
    int        sum;
    if (msg.status[7:4] != mnsq_pkg::KIND_NOTE_OFF &&
        msg.status[7:4] != mnsq_pkg::KIND_NOTE_ON) return;
    sum       = snap_to_scale(int'(msg.note)) + int'(transpose);
    want      = msg;
    want.note = (sum > int'(mnsq_pkg::NOTE_MAX)) ? mnsq_pkg::NOTE_MAX : 7'(sum);
    pending_notes = {pending_notes, want};
  endfunction

  // compare one result transfer against the oldest expectation
  function void check_result(midi_msg_t got);
    midi_msg_t want;
    if (pending_notes.size() == 0) begin
      $error("result with nothing pending: status %h note %0d velocity %0d",
             got.status, got.note, got.velocity);
      errors++;
      return;
    end
    want = pending_notes.pop_front();
    if (got.status !== want.status) begin
      $error("out_status: expected %h, actual %h", want.status, got.status);
      errors++;
    end
    if (got.note !== want.note) begin
      $error("out_note: expected %0d, actual %0d", want.note, got.note);
      errors++;
    end
    if (got.velocity !== want.velocity) begin
      $error("out_velocity: expected %0d, actual %0d", want.velocity, got.velocity);
      errors++;
    end
  endfunction
endclass

module tb_midi_note_scale_quantizer;
  import mnsq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int ITEM_TARGET  = 950;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct = 28;
  int recv_idle_pct = 58;
  int items_sent    = 0;

  note_quant_board board = new();

  mnsq_msg_in_if  in_if ();
  mnsq_msg_out_if out_if ();

  midi_note_scale_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one message transfer, with a random gap in front of it
  task automatic send_msg(input logic [7:0] st, input logic [6:0] nt,
                          input logic [6:0] vl);
    int        gap;
    midi_msg_t msg;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.status_byte <= st;
    in_if.note_number <= nt;
    in_if.velocity    <= vl;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    msg.status   = st;
    msg.note     = nt;
    msg.velocity = vl;
    board.note_input(msg);
    items_sent++;
  endtask

  // register write once the pipeline has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (board.pending_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [3:0] scale, input logic [3:0] root,
                            input logic [6:0] shift);
    write_reg(CFG_SCALE_SELECT, CFG_DATA_W'(scale));
    write_reg(CFG_ROOT_NOTE, CFG_DATA_W'(root));
    write_reg(CFG_TRANSPOSE_AMOUNT, CFG_DATA_W'(shift));
  endtask

  // result sink: check each transfer, then pick the next ready
  initial begin
    midi_msg_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
          got.status   = out_if.out_status;
          got.note     = out_if.out_note;
          got.velocity = out_if.out_velocity;
          board.check_result(got);
        end
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    int         n_items;
    logic [3:0] scale_pick;
    logic [3:0] root_pick;
    logic [6:0] shift_pick;
    logic [7:0] st;
    logic [6:0] nt;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.status_byte <= '0;
    in_if.note_number <= '0;
    in_if.velocity    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: chromatic, no shift; status edges and dropped kinds
    send_msg({KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
    send_msg({KIND_NOTE_ON, 4'hF}, 7'd127, 7'd127);
    send_msg({KIND_NOTE_OFF, 4'hF}, 7'd64, 7'd127);
    send_msg({KIND_NOTE_ON, 4'h0}, 7'd127, 7'd0);
    send_msg(8'h00, 7'd10, 7'd10);
    send_msg(8'h7F, 7'd127, 7'd127);
    send_msg(8'hA0, 7'd60, 7'd100);
    send_msg(8'hFF, 7'd0, 7'd1);

    // unused scale code, root past eleven, full shift saturating
    set_config(4'd15, 4'd15, 7'd127);
    write_reg(CFG_SPARE_INDEX, 7'h7F);
    send_msg({KIND_NOTE_ON, 4'h3}, 7'd0, 7'd64);
    send_msg({KIND_NOTE_OFF, 4'h3}, 7'd5, 7'd64);
    send_msg({KIND_NOTE_ON, 4'h9}, 7'd127, 7'd1);

    // sparse triad, root twelve wraps to zero
    set_config(4'd14, 4'd12, 7'd0);
    send_msg({KIND_NOTE_ON, 4'h1}, 7'd0, 7'd33);
    send_msg({KIND_NOTE_ON, 4'h1}, 7'd127, 7'd33);
    send_msg({KIND_NOTE_OFF, 4'h1}, 7'd64, 7'd33);

    // tie goes upward, snapped-up note then saturates
    set_config(4'd8, 4'd0, 7'd5);
    send_msg({KIND_NOTE_ON, 4'h7}, 7'd2, 7'd90);
    send_msg({KIND_NOTE_ON, 4'h7}, 7'd126, 7'd90);
    send_msg({KIND_NOTE_OFF, 4'h7}, 7'd0, 7'd90);

    // random phases with new settings each
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 28;
      end
      scale_pick = 4'($urandom_range(15));
      root_pick  = 4'($urandom_range(15));
      case ($urandom_range(3))
        0:       shift_pick = 7'd0;
        1:       shift_pick = 7'd127;
        default: shift_pick = 7'($urandom_range(127));
      endcase
      set_config(scale_pick, root_pick, shift_pick);
      if ($urandom_range(4) == 0) write_reg(CFG_SPARE_INDEX, 7'($urandom));
      n_items = $urandom_range(64, 16);
      repeat (n_items) begin
        // mostly note messages, some of every other status
        if ($urandom_range(4) != 0)
          st = {($urandom_range(1) ? KIND_NOTE_ON : KIND_NOTE_OFF), 4'($urandom)};
        else
          st = 8'($urandom);
        if ($urandom_range(7) == 0)
          nt = $urandom_range(1) ? 7'd127 : 7'd0;
        else
          nt = 7'($urandom_range(127));
        send_msg(st, nt, 7'($urandom));
      end
    end

    // drain and report
    in_if.valid <= 1'b0;
    while (board.pending_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/mnsq_pkg.sv
rtl/mnsq_ifs.sv
rtl/mnsq_cfg_regs.sv
rtl/midi_note_scale_quantizer.sv
tb/tb_midi_note_scale_quantizer.sv
